/* rtl/rhcc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rhcc_pkg: shared types, constants and functions
// Record layout constants, CRC-32 byte update, payload and register structs.
// ----------------------------------------------------------------------------
package rhcc_pkg;

   localparam int MAX_RECORD_BYTES = 256;
   // byte position saturates at MAX_RECORD_BYTES, so it must hold that value
   localparam int POS_W = $clog2(MAX_RECORD_BYTES + 1);
   // wide enough for the position plus one and for crc_field_offset + 4
   localparam int CMP_W = ((POS_W > 9) ? POS_W : 9) + 1;

   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam int CRC_FIELD_BYTES = 4;
   localparam int HEADER_BYTES = 6;
   localparam int MAGIC_BYTES = 4;

   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SEAL_MODE        = 2'd0,
      CSR_EXPECTED_MAGIC   = 2'd1,
      CSR_EXPECTED_VERSION = 2'd2,
      CSR_CRC_FIELD_OFFSET = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_MAGIC   = 3'd1,
      ST_BAD_VERSION = 3'd2,
      ST_BAD_CRC     = 3'd3,
      ST_BAD_LENGTH  = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] record_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] crc_value;
   } rsp_payload_type;

   typedef struct packed {
      logic        seal_mode;
      logic [31:0] expected_magic;
      logic [15:0] expected_version;
      logic [7:0]  crc_field_offset;
   } cfg_type;

   // reflected crc-32, one byte, eight bit steps unrolled
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

/* rtl/rhcc_csr.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rhcc_csr: configuration registers
// Holds mode, expected header and crc field offset; always ready.
// ----------------------------------------------------------------------------
module rhcc_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [rhcc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]                      csr_wdata,
   output rhcc_pkg::cfg_type                     cfg
);
   import rhcc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_SEAL_MODE:        cfg_in.seal_mode = csr_wdata[0];
            CSR_EXPECTED_MAGIC:   cfg_in.expected_magic = csr_wdata;
            CSR_EXPECTED_VERSION: cfg_in.expected_version = csr_wdata[15:0];
            CSR_CRC_FIELD_OFFSET: cfg_in.crc_field_offset = csr_wdata[7:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.seal_mode <= 1'b0;
         cfg_ff.expected_magic <= 32'd0;
         cfg_ff.expected_version <= 16'd0;
         cfg_ff.crc_field_offset <= 8'd8;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/rhcc_in_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rhcc_in_stage: input register
// Captures one record byte per transfer and holds it until the check stage
// takes it.
// ----------------------------------------------------------------------------
module rhcc_in_stage (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire rhcc_pkg::req_payload_type req_payload,
   input  wire logic                      take,
   output logic                           item_valid,
   output rhcc_pkg::req_payload_type      item
);
   import rhcc_pkg::*;

   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type in_data_ff;
   logic            load;

   assign req_stall  = in_valid_ff & ~take;
   assign load       = req_valid & ~req_stall;
   assign item_valid = in_valid_ff;
   assign item       = in_data_ff;

   always_comb begin
      if (load) begin
         in_valid_in = 1'b1;
      end else if (take) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_data_ff <= req_payload;
      end
   end

endmodule
`default_nettype wire

/* rtl/rhcc_check.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rhcc_check: record state and result register
// Runs the crc and header checks one byte per cycle, unless a last byte waits
// on a stalled result, and registers the result on the last byte of a record.
// ----------------------------------------------------------------------------
module rhcc_check (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire rhcc_pkg::cfg_type         cfg,
   input  wire logic                      item_valid,
   input  wire rhcc_pkg::req_payload_type item,
   output logic                           take,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output rhcc_pkg::rsp_payload_type      rsp_payload
);
   import rhcc_pkg::*;

   logic [31:0]      crc_ff, crc_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             magic_ok_ff, magic_ok_in;
   logic             version_ok_ff, version_ok_in;
   logic [31:0]      capt_ff, capt_in;
   logic             len_bad_ff, len_bad_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_data_ff, rsp_data_in;

   logic [CMP_W-1:0] pos_ext, off_ext, off_end, need, diff;
   logic             in_magic, in_version, in_field, at_max;
   logic [7:0]       hdr_byte, eff_byte;
   logic [31:0]      crc_next, crc_final;
   logic             bad_len;
   logic             rsp_free;

   // a result waiting on a stalled output blocks only a last byte
   assign rsp_free = ~rsp_valid_ff | ~rsp_stall;
   assign take = item_valid & (~item.last_byte | rsp_free);

   always_comb begin
      pos_ext = CMP_W'(pos_ff);
      off_ext = CMP_W'(cfg.crc_field_offset);
      off_end = off_ext + CMP_W'(CRC_FIELD_BYTES);
      need = (off_end < CMP_W'(HEADER_BYTES)) ? CMP_W'(HEADER_BYTES) : off_end;
      diff = pos_ext - off_ext;
      at_max = (pos_ext >= CMP_W'(MAX_RECORD_BYTES));

      in_magic = (pos_ext < CMP_W'(MAGIC_BYTES));
      in_version = ~in_magic & (pos_ext < CMP_W'(HEADER_BYTES));
      in_field = (pos_ext >= off_ext) & (pos_ext < off_end);

      if (in_magic) begin
         hdr_byte = cfg.expected_magic[{pos_ff[1:0], 3'b000} +: 8];
      end else begin
         hdr_byte = cfg.expected_version[{pos_ff[0], 3'b000} +: 8];
      end

      eff_byte = item.record_byte;
      if (cfg.seal_mode & (in_magic | in_version)) begin
         eff_byte = hdr_byte;
      end
      // crc field enters as zero, even over the header
      if (in_field) begin
         eff_byte = 8'd0;
      end

      crc_next = crc_byte(crc_ff, eff_byte);
      crc_final = ~crc_next;

      magic_ok_in = magic_ok_ff & ~(in_magic & (item.record_byte != hdr_byte));
      version_ok_in = version_ok_ff & ~(in_version & (item.record_byte != hdr_byte));
      capt_in = capt_ff;
      if (in_field) begin
         capt_in = capt_ff | (32'(item.record_byte) << {diff[1:0], 3'b000});
      end
      len_bad_in = len_bad_ff | at_max;
      pos_in = at_max ? pos_ff : pos_ff + POS_W'(1);
      crc_in = crc_next;

      bad_len = len_bad_in | ((pos_ext + CMP_W'(1)) < need);

      rsp_data_in.crc_value = crc_final;
      if (bad_len) begin
         rsp_data_in.status = ST_BAD_LENGTH;
         rsp_data_in.crc_value = 32'd0;
      end else if (cfg.seal_mode) begin
         rsp_data_in.status = ST_OK;
      end else if (~magic_ok_in) begin
         rsp_data_in.status = ST_BAD_MAGIC;
      end else if (~version_ok_in) begin
         rsp_data_in.status = ST_BAD_VERSION;
      end else if (crc_final != capt_in) begin
         rsp_data_in.status = ST_BAD_CRC;
      end else begin
         rsp_data_in.status = ST_OK;
      end

      if (take & item.last_byte) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (take && item.last_byte)) begin
         crc_ff <= CRC_INIT;
         pos_ff <= '0;
         magic_ok_ff <= 1'b1;
         version_ok_ff <= 1'b1;
         capt_ff <= 32'd0;
         len_bad_ff <= 1'b0;
      end else if (take) begin
         crc_ff <= crc_in;
         pos_ff <= pos_in;
         magic_ok_ff <= magic_ok_in;
         version_ok_ff <= version_ok_in;
         capt_ff <= capt_in;
         len_bad_ff <= len_bad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && item.last_byte) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule
`default_nettype wire

/* rtl/record_header_crc_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// record_header_crc_checker: record header and crc-32 check / seal
// Streams a stored record one byte per transfer and gives one result on the
// record's last byte: status and the crc over the record with its crc field
// zeroed (in seal mode over the expected header; zero on a length error).
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  record_byte, last_byte
//   rsp_      out        rsp_valid/rsp_stall  status, crc_value
//   csr_      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One byte per cycle sustained unless a last byte waits on a stalled result;
// the unrolled eight-bit crc update sits between the input register and the
// result register, which holds the result once the last byte passes both.
// Reset is synchronous; no clearing pass, the block is ready right after.
// A stalled result holds back only the next record's last byte.
// ----------------------------------------------------------------------------
module record_header_crc_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire rhcc_pkg::req_payload_type        req_payload,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output rhcc_pkg::rsp_payload_type             rsp_payload,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [rhcc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]                      csr_wdata
);
   import rhcc_pkg::*;

   cfg_type         cfg;
   logic            take;
   logic            item_valid;
   req_payload_type item;

   rhcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rhcc_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .take        (take),
      .item_valid  (item_valid),
      .item        (item)
   );

   rhcc_check u_check (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .item_valid  (item_valid),
      .item        (item),
      .take        (take),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // the input side only stalls with a byte held in the input register
   assert property (@(posedge clock) disable iff (reset) req_stall |-> item_valid)
      else $error("input stalled with empty input register");

   // a length error always reports a zero crc
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == ST_BAD_LENGTH) |-> rsp_payload.crc_value == 32'd0)
      else $error("length error with nonzero crc");

   // a last byte is taken only when the result register can accept it
   assert property (@(posedge clock) disable iff (reset)
      (take && item.last_byte) |-> (!rsp_valid || !rsp_stall))
      else $error("result overwritten while stalled");

   // only codes of the status list leave the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == ST_OK || rsp_payload.status == ST_BAD_MAGIC ||
                     rsp_payload.status == ST_BAD_VERSION || rsp_payload.status == ST_BAD_CRC ||
                     rsp_payload.status == ST_BAD_LENGTH))
      else $error("undefined status code");

endmodule
`default_nettype wire
